FILE: hw/rtl/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg: shared types and constants for radix integer to ASCII
// Widths, character codes and the item carried down the conversion pipeline.
// ----------------------------------------------------------------------------
package ita_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int DABBLE_STAGES = 4;
    localparam int BPS           = (VALUE_BITS + DABBLE_STAGES - 1) / DABBLE_STAGES;
    localparam int PW            = DABBLE_STAGES * BPS;
    localparam int DEC_DIGITS    = (VALUE_BITS * 3) / 10 + 1;
    localparam int BCD_W         = DEC_DIGITS * 4;
    localparam int HEX_DIGITS    = (VALUE_BITS + 3) / 4;
    localparam int HEX_W         = HEX_DIGITS * 4;
    localparam int LEN_W         = $clog2(VALUE_BITS + 2);

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_ONE   = 7'h31;
    localparam logic [6:0] CH_A     = 7'h41;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_NONE  = 7'h00;

    typedef enum logic [1:0] {
        BASE_BIN = 2'd0,
        BASE_DEC = 2'd1,
        BASE_HEX = 2'd2,
        BASE_BAD = 2'd3
    } base_t;

    typedef struct packed {
        logic                    neg;
        base_t                   base;
        logic [VALUE_BITS-1:0]   raw;
        logic [VALUE_BITS-1:0]   mag;
        logic [PW-1:0]           msh;
        logic [PW-1:0]           rsh;
        logic                    found;
        logic [LEN_W-1:0]        blen;
        logic [BCD_W-1:0]        bcd;
    } item_t;

endpackage

FILE: hw/rtl/ita_stage.sv
// ----------------------------------------------------------------------------
// ita_stage: one double-dabble pipeline stage
// Shifts BPS magnitude bits into the BCD digits and tracks binary length.
// ----------------------------------------------------------------------------
module ita_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  ita_pkg::item_t in_item,
    output logic          in_ready,
    output logic          out_valid,
    output ita_pkg::item_t out_item,
    input  logic          out_ready
);

    logic           valid_reg;
    ita_pkg::item_t item_reg;
    ita_pkg::item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next = in_item;
        for (int s = 0; s < ita_pkg::BPS; s++)
        begin
            for (int d = 0; d < ita_pkg::DEC_DIGITS; d++)
            begin
                if (item_next.bcd[d*4 +: 4] >= 4'd5)
                begin
                    item_next.bcd[d*4 +: 4] = item_next.bcd[d*4 +: 4] + 4'd3;
                end
            end
            item_next.bcd = {item_next.bcd[ita_pkg::BCD_W-2:0],
                             item_next.msh[ita_pkg::PW-1]};
            if (item_next.found)
            begin
                item_next.blen = item_next.blen + 1'b1;
            end
            else if (item_next.rsh[ita_pkg::PW-1] != item_next.neg)
            begin
                item_next.found = 1'b1;
                item_next.blen  = item_next.neg ? ita_pkg::LEN_W'(2) : ita_pkg::LEN_W'(1);
            end
            item_next.msh = {item_next.msh[ita_pkg::PW-2:0], 1'b0};
            item_next.rsh = {item_next.rsh[ita_pkg::PW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: hw/rtl/ita_emitter.sv
// ----------------------------------------------------------------------------
// ita_emitter: character serializer
// Holds one converted request and sends its text, most significant first.
// ----------------------------------------------------------------------------
module ita_emitter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  ita_pkg::item_t in_item,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [6:0]     char_code,
    output logic           last,
    output logic           error
);

    logic                      busy_reg;
    logic [ita_pkg::LEN_W-1:0] cnt_reg;
    logic [ita_pkg::LEN_W-1:0] len_reg;
    ita_pkg::item_t            item_reg;
    logic [ita_pkg::LEN_W-1:0] len_calc;
    logic [ita_pkg::LEN_W-1:0] dlen;
    logic [ita_pkg::LEN_W-1:0] hlen;
    logic [ita_pkg::HEX_W-1:0] in_magx;
    logic [ita_pkg::HEX_W-1:0] magx;
    logic [3:0]                digit;

    assign in_ready  = !busy_reg || (!out_stall && cnt_reg == '0);
    assign out_valid = busy_reg;
    assign last      = (cnt_reg == '0);
    assign error     = (item_reg.base == ita_pkg::BASE_BAD);
    assign in_magx   = ita_pkg::HEX_W'(in_item.mag);
    assign magx      = ita_pkg::HEX_W'(item_reg.mag);

    // length of the incoming text
    always_comb
    begin
        dlen = ita_pkg::LEN_W'(1);
        for (int i = 0; i < ita_pkg::DEC_DIGITS; i++)
        begin
            if (in_item.bcd[i*4 +: 4] != 4'd0)
            begin
                dlen = ita_pkg::LEN_W'(i + 1);
            end
        end
        hlen = ita_pkg::LEN_W'(1);
        for (int i = 0; i < ita_pkg::HEX_DIGITS; i++)
        begin
            if (in_magx[i*4 +: 4] != 4'd0)
            begin
                hlen = ita_pkg::LEN_W'(i + 1);
            end
        end
        unique case (in_item.base)
            ita_pkg::BASE_BIN: len_calc = in_item.found ? in_item.blen : ita_pkg::LEN_W'(1);
            ita_pkg::BASE_DEC: len_calc = dlen + ita_pkg::LEN_W'(in_item.neg);
            ita_pkg::BASE_HEX: len_calc = hlen + ita_pkg::LEN_W'(in_item.neg);
            default:           len_calc = ita_pkg::LEN_W'(1);
        endcase
    end

    // character at the current position
    always_comb
    begin
        digit     = 4'd0;
        char_code = ita_pkg::CH_NONE;
        unique case (item_reg.base)
            ita_pkg::BASE_BIN:
            begin
                char_code = ita_pkg::CH_ZERO;
                for (int i = 0; i < ita_pkg::VALUE_BITS; i++)
                begin
                    if (cnt_reg == ita_pkg::LEN_W'(i) && item_reg.raw[i])
                    begin
                        char_code = ita_pkg::CH_ONE;
                    end
                end
            end
            ita_pkg::BASE_DEC:
            begin
                for (int i = 0; i < ita_pkg::DEC_DIGITS; i++)
                begin
                    if (cnt_reg == ita_pkg::LEN_W'(i))
                    begin
                        digit = item_reg.bcd[i*4 +: 4];
                    end
                end
                char_code = ita_pkg::CH_ZERO + 7'(digit);
                if (item_reg.neg && cnt_reg == len_reg - 1'b1)
                begin
                    char_code = ita_pkg::CH_MINUS;
                end
            end
            ita_pkg::BASE_HEX:
            begin
                for (int i = 0; i < ita_pkg::HEX_DIGITS; i++)
                begin
                    if (cnt_reg == ita_pkg::LEN_W'(i))
                    begin
                        digit = magx[i*4 +: 4];
                    end
                end
                char_code = (digit < 4'd10) ? ita_pkg::CH_ZERO + 7'(digit)
                                            : ita_pkg::CH_A + 7'(digit - 4'd10);
                if (item_reg.neg && cnt_reg == len_reg - 1'b1)
                begin
                    char_code = ita_pkg::CH_MINUS;
                end
            end
            default: char_code = ita_pkg::CH_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (in_ready && in_valid)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ita_pkg::LEN_W'(len_calc - 1'b1);
        end
        else if (busy_reg && !out_stall)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
            len_reg  <= len_calc;
        end
    end

endmodule

FILE: hw/rtl/radix_integer_to_ascii.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii: signed integer to ASCII text
// Converts a signed value to binary, decimal or hex text, one char a beat.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes a request (value, base_select) when in_valid is
//   high and in_stall low. The output channel sends one character per beat
//   (char_code, last, error), most significant first; last marks the final
//   character of a request. base_select 3 gives a single beat with error set.
//   The first character of a request passes the input register, four
//   double-dabble stages and the emitter register before it appears.
//   Throughput: the emitter sends one character per cycle while out_stall is
//   low, so a request takes as many beats as its text has characters: 1 to 32
//   in binary, up to 11 in decimal, up to 9 in hex. Up to five requests wait
//   in the pipeline while the emitter works on a sixth.
//   Reset clears all valid bits and the emitter; no request is in flight.
//   When the receiver stalls, the current character holds and the pipeline
//   fills, then in_stall rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ita_pkg::VALUE_BITS-1:0] value,
    input  logic [1:0]                          base_select,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [6:0]                          char_code,
    output logic                                last,
    output logic                                error
);

    logic                                   front_valid_reg;
    ita_pkg::item_t                         front_item_reg;
    ita_pkg::item_t                         front_item_next;
    logic                                   front_ready;
    logic [ita_pkg::VALUE_BITS-1:0]         mag_calc;
    logic                                   neg_calc;

    logic           st_valid [ita_pkg::DABBLE_STAGES+1];
    ita_pkg::item_t st_item  [ita_pkg::DABBLE_STAGES+1];
    logic           st_ready [ita_pkg::DABBLE_STAGES+1];

    assign in_stall = !front_ready;
    assign front_ready = !front_valid_reg || st_ready[0];

    // sign and magnitude; the most negative value maps onto its own magnitude
    assign neg_calc = value[ita_pkg::VALUE_BITS-1];
    assign mag_calc = neg_calc ? (~value + 1'b1) : value;

    always_comb
    begin
        front_item_next       = '0;
        front_item_next.neg   = neg_calc;
        front_item_next.base  = ita_pkg::base_t'(base_select);
        front_item_next.raw   = value;
        front_item_next.mag   = mag_calc;
        front_item_next.msh   = ita_pkg::PW'(mag_calc);
        front_item_next.rsh   = ita_pkg::PW'(value);
        front_item_next.found = 1'b0;
        front_item_next.blen  = '0;
        front_item_next.bcd   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (front_ready)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_ready && in_valid)
        begin
            front_item_reg <= front_item_next;
        end
    end

    assign st_valid[0] = front_valid_reg;
    assign st_item[0]  = front_item_reg;

    // advance through the double-dabble stages
    for (genvar g = 0; g < ita_pkg::DABBLE_STAGES; g++)
    begin : g_stage
        ita_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[g]),
            .in_item   (st_item[g]),
            .in_ready  (st_ready[g]),
            .out_valid (st_valid[g+1]),
            .out_item  (st_item[g+1]),
            .out_ready (st_ready[g+1])
        );
    end

    ita_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[ita_pkg::DABBLE_STAGES]),
        .in_item   (st_item[ita_pkg::DABBLE_STAGES]),
        .in_ready  (st_ready[ita_pkg::DABBLE_STAGES]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last),
        .error     (error)
    );

    // error beat is a lone zero character
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && char_code == ita_pkg::CH_NONE)
        else $error("error beat malformed");

    // a minus sign is always followed by digits
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_code == ita_pkg::CH_MINUS |-> !last && !error)
        else $error("minus sign on last beat");

    // text continues until last is sent
    a_text_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |=> out_valid)
        else $error("text cut short");

endmodule
